### hdl/assert_macros.svh
// assertion macros shared by the level meter rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ALM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ALM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/alm_pkg.sv
// types, constants and lookup functions for the adc level meter display
// no dependencies; imported by all level meter modules
`timescale 1ns / 1ps

package alm_pkg;

	localparam int SAMPLE_W             = 10;
	localparam int LEVEL_W              = 5;
	localparam int BAR_W                = 8;
	localparam int BARS_W               = 4;
	localparam int SEG_W                = 7;
	localparam int EN_W                 = 2;
	localparam int DIGIT_W              = 4;
	localparam int TICK_W               = 4;
	localparam int TICKS_PER_CONVERSION = 10;

	typedef enum logic {
		OP_CONVERT = 1'b0,
		OP_TICK    = 1'b1
	} op_t;

	localparam logic [EN_W-1:0] EN_UNITS = 2'b01;
	localparam logic [EN_W-1:0] EN_TENS  = 2'b10;

	typedef struct packed {
		logic [SEG_W-1:0]  segments;
		logic [EN_W-1:0]   digit_enable;
		logic              start;
		logic [TICK_W-1:0] tick_next;
	} scan_t;

	function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] code;
		case (digit)
			4'd0:    code = 7'h3F;
			4'd1:    code = 7'h06;
			4'd2:    code = 7'h5B;
			4'd3:    code = 7'h4F;
			4'd4:    code = 7'h66;
			4'd5:    code = 7'h6D;
			4'd6:    code = 7'h7D;
			4'd7:    code = 7'h07;
			4'd8:    code = 7'h7F;
			4'd9:    code = 7'h6F;
			default: code = '0;
		endcase
		return code;
	endfunction

	function automatic logic [BAR_W-1:0] thermometer(input logic [BARS_W-1:0] bars);
		logic [BAR_W-1:0] mask;
		for (int i = 0; i < BAR_W; i++) begin
			mask[i] = (BARS_W'(i) < bars);
		end
		return mask;
	endfunction

endpackage

### hdl/adc_level_meter_display_core.sv
// top level of the adc level meter with multiplexed two-digit display
// depends on alm_pkg, alm_level_scale, alm_digit_scan, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one transaction per clock while in_stall is low and returns exactly
// one result transaction for each: an input register (_s1) feeds short
// scaling and digit-select logic whose result lands in the output register,
// which also holds the bar, segment and enable state. A conversion updates
// the stored level and the bar; a tick drives one digit and counts toward the
// next conversion request. in_stall rises only while the output register is
// full and stalled and the input register is occupied.
module adc_level_meter_display_core import alm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  logic [SAMPLE_W-1:0] sample_a,
	input  logic [SAMPLE_W-1:0] sample_b,
	input  logic [SAMPLE_W-1:0] sample_c,
	input  logic [SAMPLE_W-1:0] sample_d,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [BAR_W-1:0]    led_bar,
	output logic [SEG_W-1:0]    segments,
	output logic [EN_W-1:0]     digit_enable,
	output logic                start_conversion
);

	logic                valid_s1;
	op_t                 op_s1;
	logic [SAMPLE_W-1:0] sample_a_s1;
	logic [SAMPLE_W-1:0] sample_b_s1;
	logic [SAMPLE_W-1:0] sample_c_s1;
	logic [SAMPLE_W-1:0] sample_d_s1;

	logic                out_valid_q;
	logic [BAR_W-1:0]    led_bar_q;
	logic [SEG_W-1:0]    segments_q;
	logic [EN_W-1:0]     enable_q;
	logic                start_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                show_units_q;
	logic [TICK_W-1:0]   tick_q;

	logic                advance;
	logic [LEVEL_W-1:0]  new_level;
	logic [BAR_W-1:0]    new_bar;
	scan_t               scan;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1       <= op_t'(operation);
			sample_a_s1 <= sample_a;
			sample_b_s1 <= sample_b;
			sample_c_s1 <= sample_c;
			sample_d_s1 <= sample_d;
		end
	end

	alm_level_scale u_level_scale (
		.sample_a (sample_a_s1),
		.sample_b (sample_b_s1),
		.sample_c (sample_c_s1),
		.sample_d (sample_d_s1),
		.level    (new_level),
		.bar      (new_bar)
	);

	alm_digit_scan u_digit_scan (
		.level      (level_q),
		.show_units (show_units_q),
		.tick_count (tick_q),
		.scan       (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			led_bar_q    <= '0;
			segments_q   <= '0;
			enable_q     <= '0;
			start_q      <= 1'b0;
			level_q      <= '0;
			show_units_q <= 1'b0;
			tick_q       <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				case (op_s1)
					OP_CONVERT: begin
						level_q   <= new_level;
						led_bar_q <= new_bar;
						start_q   <= 1'b0;
					end
					default: begin
						segments_q   <= scan.segments;
						enable_q     <= scan.digit_enable;
						start_q      <= scan.start;
						show_units_q <= !show_units_q;
						tick_q       <= scan.tick_next;
					end
				endcase
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign led_bar          = led_bar_q;
	assign segments         = segments_q;
	assign digit_enable     = enable_q;
	assign start_conversion = start_q;

	`ALM_ASSERT_NOW(a_stall_needs_item, clk, arst_n, in_stall, valid_s1 && out_valid_q)
	`ALM_ASSERT_NOW(a_bar_thermometer, clk, arst_n, out_valid_q,
		(led_bar_q & (led_bar_q + 8'd1)) == 8'd0)
	`ALM_ASSERT_NOW(a_start_on_tick, clk, arst_n, out_valid_q && start_q,
		enable_q == EN_UNITS || enable_q == EN_TENS)
	`ALM_ASSERT_NEXT(a_tick_toggles_digit, clk, arst_n,
		advance && valid_s1 && op_s1 == OP_TICK, show_units_q != $past(show_units_q))

endmodule

### hdl/alm_level_scale.sv
// conversion path: mean of four samples scaled to display and bar levels
// depends on alm_pkg
`timescale 1ns / 1ps

module alm_level_scale import alm_pkg::*; (
	input  logic [SAMPLE_W-1:0] sample_a,
	input  logic [SAMPLE_W-1:0] sample_b,
	input  logic [SAMPLE_W-1:0] sample_c,
	input  logic [SAMPLE_W-1:0] sample_d,
	output logic [LEVEL_W-1:0]  level,
	output logic [BAR_W-1:0]    bar
);

	logic [SAMPLE_W+1:0] sum;
	logic [SAMPLE_W-1:0] avg;
	logic [13:0]         lvl_x;
	logic [3:0]          lvl_q0;
	logic [10:0]         lvl_r;
	logic [3:0]          lvl_q;
	logic [12:0]         bar_x;
	logic [2:0]          bar_q0;
	logic [10:0]         bar_r;
	logic [2:0]          bar_q;

	always_comb begin
		sum = {2'b00, sample_a} + {2'b00, sample_b} + {2'b00, sample_c} + {2'b00, sample_d};
		avg = sum[SAMPLE_W+1:2];

		// divide by 1023: q0 = x >> 10, remainder = low bits + q0, one correction
		lvl_x  = 14'({4'd0, avg} * 14'd15) + 14'd511;
		lvl_q0 = lvl_x[13:10];
		lvl_r  = {1'b0, lvl_x[9:0]} + {7'd0, lvl_q0};
		lvl_q  = lvl_q0 + {3'd0, (lvl_r >= 11'd1023)};
		level  = {1'b0, lvl_q} + 5'd1;

		bar_x  = 13'({3'd0, avg} * 13'd7) + 13'd511;
		bar_q0 = bar_x[12:10];
		bar_r  = {1'b0, bar_x[9:0]} + {8'd0, bar_q0};
		bar_q  = bar_q0 + {2'd0, (bar_r >= 11'd1023)};
		bar    = thermometer({1'b0, bar_q} + 4'd1);
	end

endmodule

### hdl/alm_digit_scan.sv
// tick path: digit select, segment lookup and conversion tick counter
// depends on alm_pkg
`timescale 1ns / 1ps

module alm_digit_scan import alm_pkg::*; (
	input  logic [LEVEL_W-1:0] level,
	input  logic               show_units,
	input  logic [TICK_W-1:0]  tick_count,
	output scan_t              scan
);

	logic [DIGIT_W-1:0] tens;
	logic [LEVEL_W-1:0] units;
	logic [TICK_W:0]    tick_inc;

	always_comb begin
		if (level >= LEVEL_W'(30)) begin
			tens  = DIGIT_W'(3);
			units = level - LEVEL_W'(30);
		end else if (level >= LEVEL_W'(20)) begin
			tens  = DIGIT_W'(2);
			units = level - LEVEL_W'(20);
		end else if (level >= LEVEL_W'(10)) begin
			tens  = DIGIT_W'(1);
			units = level - LEVEL_W'(10);
		end else begin
			tens  = '0;
			units = level;
		end

		if (show_units) begin
			scan.segments     = seg_code(units[DIGIT_W-1:0]);
			scan.digit_enable = EN_UNITS;
		end else begin
			scan.segments     = seg_code(tens);
			scan.digit_enable = EN_TENS;
		end

		scan.start = (tick_count == '0);
		tick_inc   = {1'b0, tick_count} + (TICK_W+1)'(1);
		if (tick_inc >= (TICK_W+1)'(TICKS_PER_CONVERSION)) begin
			scan.tick_next = '0;
		end else begin
			scan.tick_next = tick_inc[TICK_W-1:0];
		end
	end

endmodule
